### design/char_class_range_matcher_assert.svh
// assertion macros for the character class range matcher
// used by the top level only, no other dependencies
`ifndef CHAR_CLASS_RANGE_MATCHER_ASSERT_SVH
`define CHAR_CLASS_RANGE_MATCHER_ASSERT_SVH
`ifndef SYNTHESIS
`define CCRM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define CCRM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CCRM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define CCRM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### design/ccrm_pkg.sv
// shared constants, codes and types of the character class range matcher
// no dependencies
`default_nettype none
package ccrm_pkg;
	localparam int RANGE_SLOTS = 64;
	localparam int SLOT_W = $clog2(RANGE_SLOTS);
	localparam int CNT_W = $clog2(RANGE_SLOTS + 1);
	localparam int COUNT_W = 7;
	localparam int IDX_W = 6;
	localparam int CP_W = 21;
	localparam int RAM_W = 2 * CP_W;
	localparam logic [CP_W-1:0] ASCII_TOP = CP_W'(127);

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SEARCH = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] waddr;
		logic [RAM_W-1:0]  wdata;
		logic              re;
		logic [SLOT_W-1:0] raddr;
	} ram_req_t;

	typedef struct packed {
		logic valid;
		logic member;
	} result_t;
endpackage
`default_nettype wire

### design/ccrm_channels.sv
// valid/ready channel interfaces for request and response items
// depends on ccrm_pkg
`default_nettype none
interface ccrm_req_if;
	logic                      valid;
	logic                      ready;
	logic                      operation;
	logic [ccrm_pkg::IDX_W-1:0] slot_index;
	logic [ccrm_pkg::CP_W-1:0]  span_first;
	logic [ccrm_pkg::CP_W-1:0]  span_last;
	logic [ccrm_pkg::CP_W-1:0]  code_point;

	modport source (output valid, operation, slot_index, span_first, span_last,
		code_point, input ready);
	modport sink (input valid, operation, slot_index, span_first, span_last,
		code_point, output ready);
endinterface

interface ccrm_rsp_if;
	logic valid;
	logic ready;
	logic member;
	logic ascii_only;

	modport source (output valid, member, ascii_only, input ready);
	modport sink (input valid, member, ascii_only, output ready);
endinterface
`default_nettype wire

### design/ccrm_ram.sv
// generic single write port, single read port synchronous ram
// read data registered; no dependencies
`default_nettype none
module ccrm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

### design/ccrm_flags.sv
// per-slot non-ascii flags and the class-wide ascii_only reduction
// depends on ccrm_pkg
`default_nettype none
module ccrm_flags (
	input  wire logic                      clk,
	input  wire ccrm_pkg::ram_req_t        ram_req,
	input  wire logic [ccrm_pkg::CNT_W-1:0] eff_count,
	output logic                           ascii_only
);
	logic [ccrm_pkg::RANGE_SLOTS-1:0] wide_q;
	logic [ccrm_pkg::CP_W-1:0] first;
	logic [ccrm_pkg::CP_W-1:0] last;
	logic [ccrm_pkg::RANGE_SLOTS-1:0] hits;

	assign first = ram_req.wdata[ccrm_pkg::RAM_W-1:ccrm_pkg::CP_W];
	assign last  = ram_req.wdata[ccrm_pkg::CP_W-1:0];

	always_ff @(posedge clk) begin
		if (ram_req.we) begin
			wide_q[ram_req.waddr] <= (first > ccrm_pkg::ASCII_TOP) ||
				(last > ccrm_pkg::ASCII_TOP);
		end
	end

	// only slots below the active count take part
	always_comb begin
		for (int i = 0; i < ccrm_pkg::RANGE_SLOTS; i++) begin
			hits[i] = wide_q[i] && (32'(i) < 32'(eff_count));
		end
	end

	assign ascii_only = ~|hits;
endmodule
`default_nettype wire

### design/ccrm_search.sv
// request sequencer: slot writes and binary search over the range memory
// depends on ccrm_pkg and ccrm_channels
`default_nettype none
module ccrm_search (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	ccrm_req_if.sink                       req,
	input  wire logic [ccrm_pkg::CNT_W-1:0] eff_count,
	input  wire logic                      out_free,
	output ccrm_pkg::ram_req_t             ram_req,
	input  wire logic [ccrm_pkg::RAM_W-1:0] ram_rdata,
	output ccrm_pkg::result_t              result
);
	ccrm_pkg::state_t state_q, state_d;
	logic [ccrm_pkg::CNT_W-1:0] lo_q, hi_q, mid_q;
	logic [ccrm_pkg::CP_W-1:0]  cp_q;
	logic                       member_q;

	logic [ccrm_pkg::CP_W-1:0]  low, high;
	logic                       below, above, hit, more, accept, is_query;
	logic [ccrm_pkg::CNT_W-1:0] nlo, nhi, nmid, first_mid;

	assign req.ready = (state_q == ccrm_pkg::ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign is_query  = (req.operation == ccrm_pkg::OP_QUERY);
	assign first_mid = eff_count >> 1;

	always_comb begin
		low   = ram_rdata[ccrm_pkg::RAM_W-1:ccrm_pkg::CP_W];
		high  = ram_rdata[ccrm_pkg::CP_W-1:0];
		below = cp_q < low;
		above = cp_q > high;
		hit   = !below && !above;
		nlo   = lo_q;
		nhi   = hi_q;
		if (below) begin
			nhi = mid_q;
		end else if (above) begin
			nlo = mid_q + ccrm_pkg::CNT_W'(1);
		end
		nmid = nlo + ((nhi - nlo) >> 1);
		more = !hit && (nlo < nhi);
	end

	always_comb begin
		ram_req.we    = accept && !is_query &&
			(32'(req.slot_index) < 32'(ccrm_pkg::RANGE_SLOTS));
		ram_req.waddr = ccrm_pkg::SLOT_W'(req.slot_index);
		ram_req.wdata = {req.span_first, req.span_last};
		if (state_q == ccrm_pkg::ST_IDLE) begin
			ram_req.re    = accept && is_query && (eff_count != '0);
			ram_req.raddr = ccrm_pkg::SLOT_W'(first_mid);
		end else begin
			ram_req.re    = (state_q == ccrm_pkg::ST_SEARCH) && more;
			ram_req.raddr = ccrm_pkg::SLOT_W'(nmid);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ccrm_pkg::ST_IDLE: begin
				if (accept) begin
					if (is_query && (eff_count != '0)) begin
						state_d = ccrm_pkg::ST_SEARCH;
					end else begin
						state_d = ccrm_pkg::ST_FINISH;
					end
				end
			end
			ccrm_pkg::ST_SEARCH: begin
				if (!more) begin
					state_d = ccrm_pkg::ST_FINISH;
				end
			end
			ccrm_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = ccrm_pkg::ST_IDLE;
				end
			end
			default: state_d = ccrm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ccrm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ccrm_pkg::ST_IDLE) begin
			if (accept) begin
				lo_q     <= '0;
				hi_q     <= eff_count;
				mid_q    <= first_mid;
				cp_q     <= req.code_point;
				member_q <= 1'b0;
			end
		end else if (state_q == ccrm_pkg::ST_SEARCH) begin
			lo_q     <= nlo;
			hi_q     <= nhi;
			mid_q    <= nmid;
			member_q <= hit;
		end
	end

	assign result.valid  = (state_q == ccrm_pkg::ST_FINISH) && out_free;
	assign result.member = member_q;
endmodule
`default_nettype wire

### design/char_class_range_matcher.sv
// top level of the character class range matcher
// depends on ccrm_pkg, ccrm_channels, ccrm_ram, ccrm_flags, ccrm_search
`default_nettype none
// Character class membership engine. A write item (operation 0) stores the
// inclusive range span_first..span_last in slot slot_index and returns member 0;
// a query item (operation 1) binary-searches the first range_count slots, which
// must be sorted ascending and written beforehand, and returns member 1 on a hit.
// Every result also carries ascii_only, set when all active ranges lie in 0..127.
// range_count is written through cfg_we/cfg_wdata and saturates at the slot count.
// The ranges live in one 64 x 42 bit memory with a registered read; the search
// reads one slot per cycle. A finished result waits in an output register while
// the next item is taken.
module char_class_range_matcher (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [ccrm_pkg::COUNT_W-1:0] cfg_wdata,
	ccrm_req_if.sink                         req,
	ccrm_rsp_if.source                       rsp
);
	logic [ccrm_pkg::COUNT_W-1:0] count_q;
	logic [ccrm_pkg::CNT_W-1:0]   eff_count;
	ccrm_pkg::ram_req_t           ram_req;
	logic [ccrm_pkg::RAM_W-1:0]   ram_rdata;
	ccrm_pkg::result_t            result;
	logic                         ascii_only;
	logic                         out_free;
	logic                         out_valid_q, member_q, ascii_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	assign eff_count = (32'(count_q) > 32'(ccrm_pkg::RANGE_SLOTS)) ?
		ccrm_pkg::CNT_W'(ccrm_pkg::RANGE_SLOTS) : ccrm_pkg::CNT_W'(count_q);

	ccrm_ram #(
		.WIDTH(ccrm_pkg::RAM_W),
		.DEPTH(ccrm_pkg::RANGE_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_req.we),
		.waddr(ram_req.waddr),
		.wdata(ram_req.wdata),
		.re   (ram_req.re),
		.raddr(ram_req.raddr),
		.rdata(ram_rdata)
	);

	ccrm_flags u_flags (
		.clk       (clk),
		.ram_req   (ram_req),
		.eff_count (eff_count),
		.ascii_only(ascii_only)
	);

	ccrm_search u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.eff_count(eff_count),
		.out_free (out_free),
		.ram_req  (ram_req),
		.ram_rdata(ram_rdata),
		.result   (result)
	);

	assign out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result.valid) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result.valid) begin
			member_q <= result.member;
			ascii_q  <= ascii_only;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.member     = member_q;
	assign rsp.ascii_only = ascii_q;

`include "char_class_range_matcher_assert.svh"

	`CCRM_ASSERT_IMP(a_member_needs_class, clk, arst_n, rsp.valid && rsp.member, eff_count != '0, "member reported for an empty class")
	`CCRM_ASSERT_NXT(a_one_item_at_a_time, clk, arst_n, req.valid && req.ready, !req.ready, "item taken while another is in flight")
	`CCRM_ASSERT_IMP(a_no_result_overwrite, clk, arst_n, result.valid, !out_valid_q || rsp.ready, "result overwrites a waiting item")
endmodule
`default_nettype wire
